// ===== hdl/bmp16_pkg.sv =====
package bmp16_pkg;

	localparam int unsigned PALETTE_ENTRIES = 256;
	localparam int unsigned PAL_AW = $clog2(PALETTE_ENTRIES);

	localparam logic [31:0] POS_OFFSET_B0 = 32'd10;
	localparam logic [31:0] POS_OFFSET_B3 = 32'd13;
	localparam logic [31:0] POS_WIDTH_B0 = 32'd18;
	localparam logic [31:0] POS_WIDTH_B3 = 32'd21;
	localparam logic [31:0] POS_HEIGHT_B0 = 32'd22;
	localparam logic [31:0] POS_HEIGHT_B3 = 32'd25;
	localparam logic [31:0] POS_DEPTH_LO = 32'd28;
	localparam logic [31:0] POS_DEPTH_HI = 32'd29;
	localparam logic [31:0] POS_DATA_MIN = 32'd30;
	localparam logic [31:0] PALETTE_START = 32'd54;
	localparam logic [31:0] MIN_DATA_OFFSET = 32'd1078;
	localparam logic [15:0] DEPTH_8BPP = 16'd8;

	localparam logic [7:0] RED_BAND_1 = 8'd42;
	localparam logic [7:0] RED_BAND_2 = 8'd126;
	localparam logic [7:0] RED_BAND_3 = 8'd210;
	localparam logic [7:0] TH_LOW = 8'd84;
	localparam logic [7:0] TH_HIGH = 8'd168;
	localparam logic [7:0] TH_GREEN_MID = 8'd60;

	localparam logic [1:0] SUB_BLUE = 2'd0;
	localparam logic [1:0] SUB_GREEN = 2'd1;
	localparam logic [1:0] SUB_RED = 2'd2;

	localparam logic [1:0] KIND_PIXEL = 2'd0;
	localparam logic [1:0] KIND_DEPTH = 2'd1;
	localparam logic [1:0] KIND_FORMAT = 2'd2;

	localparam logic CFG_ORIGIN_X = 1'b0;
	localparam logic CFG_ORIGIN_Y = 1'b1;

	typedef struct packed {
		logic              en;
		logic [PAL_AW-1:0] addr;
		logic [7:0]        blue;
		logic [7:0]        green;
		logic [7:0]        red;
	} pal_wr_t;

	// bit 0 from blue, bit 1 from green, top two bits from red band
	function automatic logic [3:0] quantize(input logic [7:0] b, input logic [7:0] g,
		input logic [7:0] r);
		logic [3:0] v;
		if (r < RED_BAND_1) begin
			v = {2'b00, g > TH_LOW, b > TH_LOW};
		end else if (r < RED_BAND_2) begin
			v = {2'b10, g > TH_HIGH, b > TH_HIGH};
		end else if (r < RED_BAND_3) begin
			v = {2'b01, g > TH_GREEN_MID, b > TH_LOW};
		end else begin
			v = {2'b11, g > TH_HIGH, b > TH_HIGH};
		end
		return v;
	endfunction

endpackage

// ===== hdl/bmp16_palette.sv =====
module bmp16_palette (
	input  logic                      clk,
	input  bmp16_pkg::pal_wr_t        wr,
	input  logic                      rd_en,
	input  logic [bmp16_pkg::PAL_AW-1:0] rd_addr,
	output logic [3:0]                rd_data
);
	import bmp16_pkg::*;

	logic [3:0] mem [PALETTE_ENTRIES];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= quantize(wr.blue, wr.green, wr.red);
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hdl/bmp8_to_16color_pixel_stream.sv =====
// A pixel or error request passes the lookup stage, then the output register, to m_axis.
// Throughput: one byte per cycle unless stalled; one palette write or read per byte.
// s_axis_tready drops only while both the lookup stage and the output register are full.
// Reset (arst_n low) clears parser state, origins and valid flags at once.
// Palette RAM is not cleared; each file rewrites it before any pixel reads it.
module bmp8_to_16color_pixel_stream #(
	parameter int unsigned MAX_DIM = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] file_byte
	input  logic [0:0]  s_axis_tuser,  // [0] file_start
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [10:0] pixel_x, [21:11] pixel_y, [25:22] color_index
	output logic [1:0]  m_axis_tuser,  // [1:0] result_kind
	output logic        m_axis_tlast,  // last_pixel
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [9:0]  cfg_data
);
	import bmp16_pkg::*;

	logic [9:0]  origin_x_q, origin_y_q;
	logic [31:0] pos_q, offset_q, width_q, height_q;
	logic [7:0]  depth_lo_q, blue_q, green_q;
	logic [10:0] col_q, row_q;
	logic [1:0]  pad_q;
	logic        halted_q;

	logic [31:0] cur_pos, cur_offset, cur_width, cur_height;
	logic [7:0]  cur_depth_lo;
	logic [10:0] cur_col, cur_row;
	logic [1:0]  cur_pad;
	logic        cur_halted;

	logic [31:0] pos_n, offset_n, width_n, height_n;
	logic [7:0]  depth_lo_n, blue_n, green_n;
	logic [10:0] col_n, row_n;
	logic [1:0]  pad_n;
	logic        halted_n;

	logic        accept, start, out_load;
	logic [7:0]  byte_in;
	logic [1:0]  lane, pad_len, sub;
	logic [10:0] rel;
	logic [15:0] depth;
	logic        in_pal, in_data;
	logic [2:0]  pad_inc;

	logic        res_valid, res_pixel, res_last;
	logic [1:0]  res_kind;
	logic [10:0] res_x, res_y;

	pal_wr_t     pal_wr;
	logic        pal_rd_en;
	logic [3:0]  pal_rd_data;

	logic        valid_s1, pixel_s1, last_s1;
	logic [1:0]  kind_s1;
	logic [10:0] x_s1, y_s1;

	logic        out_valid_q, out_last_q;
	logic [1:0]  out_kind_q;
	logic [31:0] out_data_q;

	assign accept   = s_axis_tvalid && s_axis_tready;
	assign start    = s_axis_tuser[0];
	assign byte_in  = s_axis_tdata;
	assign out_load = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || out_load;

	// file_start restarts the parse before this byte is handled
	assign cur_pos      = start ? '0 : pos_q;
	assign cur_offset   = start ? '0 : offset_q;
	assign cur_width    = start ? '0 : width_q;
	assign cur_height   = start ? '0 : height_q;
	assign cur_depth_lo = start ? '0 : depth_lo_q;
	assign cur_col      = start ? '0 : col_q;
	assign cur_row      = start ? '0 : row_q;
	assign cur_pad      = start ? '0 : pad_q;
	assign cur_halted   = start ? 1'b0 : halted_q;

	// the four-byte header fields (offset, width, height) all start at a position that is 2 mod 4
	assign lane    = cur_pos[1:0] - 2'd2;
	assign depth   = {byte_in, cur_depth_lo};
	assign in_pal  = (cur_pos >= PALETTE_START) && (cur_pos < MIN_DATA_OFFSET);
	assign rel     = cur_pos[10:0] - PALETTE_START[10:0];
	assign sub     = rel[1:0];
	assign in_data = (cur_pos >= POS_DATA_MIN) && (cur_pos >= cur_offset);
	assign pad_len = (~cur_width[1:0]) + 2'd1;
	assign pad_inc = {1'b0, cur_pad} + 3'd1;

	always_comb begin
		pos_n      = cur_pos;
		offset_n   = cur_offset;
		width_n    = cur_width;
		height_n   = cur_height;
		depth_lo_n = cur_depth_lo;
		blue_n     = blue_q;
		green_n    = green_q;
		col_n      = cur_col;
		row_n      = cur_row;
		pad_n      = cur_pad;
		halted_n   = cur_halted;
		res_valid  = 1'b0;
		res_pixel  = 1'b0;
		res_kind   = KIND_PIXEL;
		res_x      = '0;
		res_y      = '0;
		res_last   = 1'b0;
		pal_wr     = '{en: 1'b0, addr: rel[PAL_AW+1:2], blue: blue_q, green: green_q,
			red: byte_in};
		pal_rd_en  = 1'b0;

		if (!cur_halted) begin
			if (cur_pos != '1) begin
				pos_n = cur_pos + 32'd1;
			end
			if (cur_pos >= POS_OFFSET_B0 && cur_pos <= POS_OFFSET_B3) begin
				offset_n[8*lane +: 8] = byte_in;
			end else if (cur_pos >= POS_WIDTH_B0 && cur_pos <= POS_WIDTH_B3) begin
				width_n[8*lane +: 8] = byte_in;
			end else if (cur_pos >= POS_HEIGHT_B0 && cur_pos <= POS_HEIGHT_B3) begin
				height_n[8*lane +: 8] = byte_in;
			end else if (cur_pos == POS_DEPTH_LO) begin
				depth_lo_n = byte_in;
			end else if (cur_pos == POS_DEPTH_HI) begin
				if (depth != DEPTH_8BPP) begin
					res_valid = 1'b1;
					res_kind  = KIND_DEPTH;
					halted_n  = 1'b1;
				end else if (cur_offset < MIN_DATA_OFFSET || cur_width > 32'(MAX_DIM) ||
					(!cur_height[31] && cur_height > 32'(MAX_DIM))) begin
					res_valid = 1'b1;
					res_kind  = KIND_FORMAT;
					halted_n  = 1'b1;
				end else if (cur_width == '0 || cur_height == '0 || cur_height[31]) begin
					halted_n  = 1'b1;
				end
			end

			if (in_pal) begin
				case (sub)
					SUB_BLUE:  blue_n = byte_in;
					SUB_GREEN: green_n = byte_in;
					SUB_RED:   pal_wr.en = 1'b1;
					default:   ;
				endcase
			end

			// width and height are within MAX_DIM once pixel data starts
			if (in_data) begin
				if (cur_col < cur_width[10:0]) begin
					res_valid = 1'b1;
					res_pixel = 1'b1;
					pal_rd_en = 1'b1;
					res_x     = {1'b0, origin_x_q} + cur_col;
					res_y     = {1'b0, origin_y_q} + cur_height[10:0] - cur_row - 11'd1;
					res_last  = (cur_row + 11'd1 == cur_height[10:0]) &&
						(cur_col + 11'd1 == cur_width[10:0]);
					col_n     = cur_col + 11'd1;
					if (col_n == cur_width[10:0] && pad_len == 2'd0) begin
						row_n = cur_row + 11'd1;
						col_n = '0;
						pad_n = '0;
						halted_n = row_n >= cur_height[10:0];
					end
				end else begin
					pad_n = pad_inc[1:0];
					if (pad_inc >= {1'b0, pad_len}) begin
						row_n = cur_row + 11'd1;
						col_n = '0;
						pad_n = '0;
						halted_n = row_n >= cur_height[10:0];
					end
				end
			end
		end

		if (!accept) begin
			pal_wr.en = 1'b0;
			pal_rd_en = 1'b0;
		end
	end

	bmp16_palette u_palette (
		.clk     (clk),
		.wr      (pal_wr),
		.rd_en   (pal_rd_en),
		.rd_addr (byte_in),
		.rd_data (pal_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ORIGIN_X: origin_x_q <= cfg_data;
				CFG_ORIGIN_Y: origin_y_q <= cfg_data;
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			offset_q   <= '0;
			width_q    <= '0;
			height_q   <= '0;
			depth_lo_q <= '0;
			col_q      <= '0;
			row_q      <= '0;
			pad_q      <= '0;
			halted_q   <= 1'b0;
		end else if (accept) begin
			pos_q      <= pos_n;
			offset_q   <= offset_n;
			width_q    <= width_n;
			height_q   <= height_n;
			depth_lo_q <= depth_lo_n;
			col_q      <= col_n;
			row_q      <= row_n;
			pad_q      <= pad_n;
			halted_q   <= halted_n;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			blue_q  <= blue_n;
			green_q <= green_n;
		end
	end

	// lookup stage: holds the request alongside the registered palette read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= res_valid;
		end else if (out_load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pixel_s1 <= res_pixel;
			kind_s1  <= res_kind;
			x_s1     <= res_x;
			y_s1     <= res_y;
			last_s1  <= res_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_kind_q <= kind_s1;
			out_last_q <= last_s1;
			out_data_q <= {6'd0, (pixel_s1 ? pal_rd_data : 4'd0), y_s1, x_s1};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;

`ifndef SYNTH
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && out_valid_q))
		else $error("input stalled with a free stage");

	a_error_has_no_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser != KIND_PIXEL) |-> (!m_axis_tlast && m_axis_tdata == '0))
		else $error("error request carries pixel fields");

	a_halted_is_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && halted_q && !start) |=> !valid_s1)
		else $error("result produced while halted");

	a_palette_one_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(pal_wr.en && pal_rd_en))
		else $error("palette written and read in the same cycle");
`endif

endmodule
